// File: hdl/msr_pkg.sv
`default_nettype none

package msr_pkg;

   // Field widths of the request and response payloads.
   localparam int REQ_TYPE_W = 3;
   localparam int MOTOR_SEL_W = 2;
   localparam int MOTOR_SEL_SPAN = 1 << MOTOR_SEL_W;
   localparam int PIN_W = 4;
   localparam int CODE_W = 2;
   localparam int TIMER_W = 16;

   // Configuration port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_INDEX_W-1:0] CSR_PERIOD_TOP = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START_COMPARE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COMPARE_STEP = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RAMP_PERIODS = 2'd3;

   localparam logic [TIMER_W-1:0] RST_PERIOD_TOP = 16'd36000;
   localparam logic [TIMER_W-1:0] RST_START_COMPARE = 16'd26400;
   localparam logic [TIMER_W-1:0] RST_COMPARE_STEP = 16'd152;
   localparam logic [TIMER_W-1:0] RST_RAMP_PERIODS = 16'd150;

   // Request codes.
   localparam logic [REQ_TYPE_W-1:0] REQ_TICK = 3'd0;
   localparam logic [REQ_TYPE_W-1:0] REQ_EAST = 3'd1;
   localparam logic [REQ_TYPE_W-1:0] REQ_WEST = 3'd2;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP = 3'd3;
   localparam logic [REQ_TYPE_W-1:0] REQ_STOP_ALL = 3'd4;

   // Direction codes.
   localparam logic [CODE_W-1:0] DIR_STOP = 2'd0;
   localparam logic [CODE_W-1:0] DIR_EAST = 2'd1;
   localparam logic [CODE_W-1:0] DIR_WEST = 2'd2;

   // Run state codes.
   localparam logic [CODE_W-1:0] RUN_STOPPED = 2'd0;
   localparam logic [CODE_W-1:0] RUN_RAMPING = 2'd1;
   localparam logic [CODE_W-1:0] RUN_FULL = 2'd2;

   typedef struct packed {
      logic [TIMER_W-1:0] period_top;
      logic [TIMER_W-1:0] start_compare;
      logic [TIMER_W-1:0] compare_step;
      logic [TIMER_W-1:0] ramp_periods;
   } cfg_type;

   typedef struct packed {
      logic [REQ_TYPE_W-1:0] req_type;
      logic [MOTOR_SEL_W-1:0] motor_sel;
   } item_type;

   typedef struct packed {
      logic [PIN_W-1:0] enable_pins;
      logic [PIN_W-1:0] direction_pins;
      logic [CODE_W-1:0] running_state;
      logic [CODE_W-1:0] direction;
      logic ramp_busy;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/msr_req_if.sv
`default_nettype none

interface msr_req_if
   import msr_pkg::*;
   ;
   logic valid;
   logic ready;
   logic [REQ_TYPE_W-1:0] req_type;
   logic [MOTOR_SEL_W-1:0] motor_sel;

   modport source (output valid, output req_type, output motor_sel, input ready);
   modport sink (input valid, input req_type, input motor_sel, output ready);
endinterface

`default_nettype wire

// File: hdl/msr_rsp_if.sv
`default_nettype none

interface msr_rsp_if
   import msr_pkg::*;
   ;
   logic valid;
   logic ready;
   logic [PIN_W-1:0] enable_pins;
   logic [PIN_W-1:0] direction_pins;
   logic [CODE_W-1:0] running_state;
   logic [CODE_W-1:0] direction;
   logic ramp_busy;

   modport source (output valid, output enable_pins, output direction_pins,
                   output running_state, output direction, output ramp_busy,
                   input ready);
   modport sink (input valid, input enable_pins, input direction_pins,
                 input running_state, input direction, input ramp_busy,
                 output ready);
endinterface

`default_nettype wire

// File: hdl/motor_soft_start_pwm_ramp_unit.sv
`default_nettype none

// Soft-start PWM ramp controller for a bank of DC motors, one running at a
// time. Every request (a timer tick, a turn east or west command, a stop of
// one motor or a stop of all motors) yields exactly one response carrying the
// enable and direction pins of motors zero to three, the run state and
// direction of the addressed motor, and whether the ramp timer is running.
// The block accepts one request per clock cycle while its responses are taken:
// the request is first captured in an input register, and then the state
// update runs and loads the response register. That update of the timer,
// compare and ramp counters is the loop that sets the rate, since each tick
// depends on the state left by the last.
// A response that waits on the sink stalls the pipeline, but the input
// register can still take one request while it waits. Configuration registers
// (period, start compare, compare step, ramp periods) are written through the
// csr port and should only change while no request is in flight.
module motor_soft_start_pwm_ramp_unit
   import msr_pkg::*;
#(
   parameter int MOTOR_COUNT = 4
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   msr_req_if.sink                     req,
   msr_rsp_if.source                   rsp,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   cfg_type    cfg;
   item_type   s1_item_ff;
   logic       s1_valid_ff, s1_valid_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       advance;
   logic       load;
   logic       process;
   result_type result;

   // The pipeline moves whenever the response register is empty or being
   // taken this cycle.
   assign advance = !rsp_valid_ff || rsp.ready;
   assign req.ready = !s1_valid_ff || advance;
   assign load = req.valid && req.ready;
   assign process = s1_valid_ff && advance;

   always_comb begin
      s1_valid_in = load || (s1_valid_ff && !advance);
      rsp_valid_in = process || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The request payload needs no reset; its valid bit guards it.
   always_ff @(posedge clock) begin
      if (load) begin
         s1_item_ff.req_type <= req.req_type;
         s1_item_ff.motor_sel <= req.motor_sel;
      end
   end

   msr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   msr_core #(
      .MOTOR_COUNT (MOTOR_COUNT)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (process),
      .item   (s1_item_ff),
      .cfg    (cfg),
      .result (result)
   );

   assign rsp.valid = rsp_valid_ff;
   assign rsp.enable_pins = result.enable_pins;
   assign rsp.direction_pins = result.direction_pins;
   assign rsp.running_state = result.running_state;
   assign rsp.direction = result.direction;
   assign rsp.ramp_busy = result.ramp_busy;

   // A processed request always produces a response in the next cycle.
   a_process_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp.valid)
      else $error("processed request did not produce a response");

   // A captured request held back by a stalled response is not dropped.
   a_stalled_item_kept: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !advance) |=> s1_valid_ff)
      else $error("stalled request was lost");

   // Only one motor may ever be driven at a time.
   a_single_enable: assert property (@(posedge clock) disable iff (reset)
      rsp.valid |-> $onehot0(rsp.enable_pins))
      else $error("more than one motor enabled");

   // A motor reported as running fully implies the ramp timer has stopped.
   a_full_means_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && rsp.running_state == RUN_FULL) |-> !rsp.ramp_busy)
      else $error("motor running fully while ramp timer busy");

endmodule

`default_nettype wire

// File: hdl/msr_csr.sv
`default_nettype none

module msr_csr
   import msr_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata,
   output cfg_type                     cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_PERIOD_TOP: cfg_in.period_top = csr_wdata;
            CSR_START_COMPARE: cfg_in.start_compare = csr_wdata;
            CSR_COMPARE_STEP: cfg_in.compare_step = csr_wdata;
            CSR_RAMP_PERIODS: cfg_in.ramp_periods = csr_wdata;
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_top <= RST_PERIOD_TOP;
         cfg_ff.start_compare <= RST_START_COMPARE;
         cfg_ff.compare_step <= RST_COMPARE_STEP;
         cfg_ff.ramp_periods <= RST_RAMP_PERIODS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

`default_nettype wire

// File: hdl/msr_core.sv
`default_nettype none

module msr_core
   import msr_pkg::*;
#(
   parameter int MOTOR_COUNT = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   input  wire logic step,
   input  wire item_type item,
   input  wire cfg_type  cfg,
   output result_type result
);

   // Motors past the reach of the 2-bit id can never be commanded, so their
   // pins stay low and need no storage.
   localparam int NM = (MOTOR_COUNT < MOTOR_SEL_SPAN) ? MOTOR_COUNT : MOTOR_SEL_SPAN;

   logic [TIMER_W-1:0]    cnt_ff, cnt_in;
   logic [TIMER_W-1:0]    cmp_ff, cmp_in;
   logic [TIMER_W-1:0]    ramp_ff, ramp_in;
   logic                  run_ff, run_in;
   logic [MOTOR_SEL_W-1:0] cur_ff, cur_in;
   logic [CODE_W-1:0]     dir_ff [NM];
   logic [CODE_W-1:0]     dir_in [NM];
   logic [CODE_W-1:0]     st_ff [NM];
   logic [CODE_W-1:0]     st_in [NM];
   logic [NM-1:0]         en_ff, en_in;
   logic [NM-1:0]         dbit_ff, dbit_in;
   result_type            result_ff, result_in;

   logic [NM-1:0]         id_sel, cur_sel;
   logic                  id_ok;
   logic                  wrap, ramp_end, hit, repeat_turn;
   logic [TIMER_W-1:0]    cnt_inc, ramp_inc, cmp_dec;
   logic [CODE_W-1:0]     turn_dir, id_dir, id_st;

   always_comb begin
      id_ok = 32'(item.motor_sel) < NM;
      for (int i = 0; i < NM; i++) begin
         id_sel[i] = item.motor_sel == MOTOR_SEL_W'(i);
         cur_sel[i] = cur_ff == MOTOR_SEL_W'(i);
      end

      // Timer arithmetic for one tick; all terms come straight from registers.
      wrap = cnt_ff >= cfg.period_top;
      cnt_inc = cnt_ff + TIMER_W'(1);
      ramp_inc = ramp_ff + TIMER_W'(1);
      ramp_end = ramp_inc >= cfg.ramp_periods;
      cmp_dec = (cmp_ff > cfg.compare_step) ? (cmp_ff - cfg.compare_step) : '0;
      // After a wrap the counter is zero, so it meets the new compare value
      // exactly when the subtraction saturates.
      hit = wrap ? (cmp_ff <= cfg.compare_step) : (cnt_inc == cmp_ff);

      turn_dir = (item.req_type == REQ_EAST) ? DIR_EAST : DIR_WEST;
      id_dir = DIR_STOP;
      for (int i = 0; i < NM; i++) begin
         if (id_sel[i]) begin
            id_dir = dir_ff[i];
         end
      end
      repeat_turn = (cur_ff == item.motor_sel) && (id_dir == turn_dir);

      cnt_in = cnt_ff;
      cmp_in = cmp_ff;
      ramp_in = ramp_ff;
      run_in = run_ff;
      cur_in = cur_ff;
      dir_in = dir_ff;
      st_in = st_ff;
      en_in = en_ff;
      dbit_in = dbit_ff;

      case (item.req_type)
         REQ_TICK: begin
            if (run_ff) begin
               if (wrap) begin
                  cnt_in = '0;
                  cmp_in = cmp_dec;
                  if (ramp_end) begin
                     run_in = 1'b0;
                     ramp_in = '0;
                     en_in = en_ff | cur_sel;
                     for (int i = 0; i < NM; i++) begin
                        if (cur_sel[i]) begin
                           st_in[i] = RUN_FULL;
                        end
                     end
                  end else begin
                     ramp_in = ramp_inc;
                     en_in = en_ff & ~cur_sel;
                     for (int i = 0; i < NM; i++) begin
                        if (cur_sel[i]) begin
                           st_in[i] = RUN_RAMPING;
                        end
                     end
                  end
               end else begin
                  cnt_in = cnt_inc;
               end
               if (!(wrap && ramp_end) && hit) begin
                  en_in = en_in | cur_sel;
               end
            end
         end
         REQ_EAST, REQ_WEST: begin
            if (id_ok && !repeat_turn) begin
               for (int i = 0; i < NM; i++) begin
                  dir_in[i] = id_sel[i] ? turn_dir : DIR_STOP;
                  st_in[i] = RUN_STOPPED;
                  if (id_sel[i]) begin
                     dbit_in[i] = (turn_dir == DIR_EAST);
                  end
               end
               en_in = '0;
               cur_in = item.motor_sel;
               ramp_in = '0;
               cmp_in = cfg.start_compare;
               cnt_in = '0;
               run_in = 1'b1;
            end
         end
         REQ_STOP: begin
            if (id_ok) begin
               run_in = 1'b0;
               ramp_in = '0;
               en_in = en_ff & ~id_sel;
               for (int i = 0; i < NM; i++) begin
                  if (id_sel[i]) begin
                     dir_in[i] = DIR_STOP;
                     st_in[i] = RUN_STOPPED;
                  end
               end
            end
         end
         REQ_STOP_ALL: begin
            run_in = 1'b0;
            ramp_in = '0;
            en_in = '0;
            for (int i = 0; i < NM; i++) begin
               dir_in[i] = DIR_STOP;
               st_in[i] = RUN_STOPPED;
            end
         end
         default: begin
            run_in = run_ff;
         end
      endcase

      id_st = RUN_STOPPED;
      for (int i = 0; i < NM; i++) begin
         if (id_sel[i]) begin
            id_st = st_in[i];
         end
      end
      result_in.enable_pins = PIN_W'(en_in);
      result_in.direction_pins = PIN_W'(dbit_in);
      result_in.running_state = id_st;
      result_in.direction = DIR_STOP;
      for (int i = 0; i < NM; i++) begin
         if (id_sel[i]) begin
            result_in.direction = dir_in[i];
         end
      end
      result_in.ramp_busy = run_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         cmp_ff <= '0;
         ramp_ff <= '0;
         run_ff <= 1'b0;
         cur_ff <= '0;
         en_ff <= '0;
         dbit_ff <= '0;
         for (int i = 0; i < NM; i++) begin
            dir_ff[i] <= DIR_STOP;
            st_ff[i] <= RUN_STOPPED;
         end
      end else if (step) begin
         cnt_ff <= cnt_in;
         cmp_ff <= cmp_in;
         ramp_ff <= ramp_in;
         run_ff <= run_in;
         cur_ff <= cur_in;
         en_ff <= en_in;
         dbit_ff <= dbit_in;
         dir_ff <= dir_in;
         st_ff <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

`default_nettype wire
